// ----- rtl/fcm_pkg.sv -----
// Shared constants and codes for the framed command matcher.
`default_nettype none
package fcm_pkg;
    localparam int LINE_LEN_DEF  = 64;
    localparam int MAX_CMDS_DEF  = 16;

    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_QM    = 8'h3F;  // '?'

    localparam logic [7:0] EOL_FIRST_RST  = 8'd13;
    localparam logic [7:0] EOL_SECOND_RST = 8'd10;
    localparam logic [7:0] SEP_A_RST      = 8'd32;
    localparam logic [7:0] SEP_B_RST      = 8'd61;

    localparam logic [1:0] REG_EOL_FIRST  = 2'd0;
    localparam logic [1:0] REG_EOL_SECOND = 2'd1;
    localparam logic [1:0] REG_SEP_A      = 2'd2;
    localparam logic [1:0] REG_SEP_B      = 2'd3;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_FLAGS = 2'd2;

    localparam logic [1:0] ST_DISPATCHED = 2'd0;
    localparam logic [1:0] ST_NO_MATCH   = 2'd1;
    localparam logic [1:0] ST_NO_HANDLER = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    localparam logic [1:0] ACT_TEST  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_EXEC  = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/framed_command_matcher.sv -----
// Top level of the framed command matcher: frame hunting, line buffer and table matcher.
`default_nettype none
// Bytes and table writes are taken while the matcher is idle and the result slot is
// free; configuration writes are never stalled. A byte that completes an end-of-line
// pair starts a judgment run that holds s_tready low: a scan of the line up to the
// end of the first token and then a check for its end (a line with no token goes
// straight to the result), a fetch of the action text, then a compare of the name
// characters for each table entry tried until the first match, a final check when
// no entry matches, and a hand-over of the result. The line buffer has a single
// read port, shared by all phases; the name memory has a single read port too,
// used by the match phase. Overflow results appear on m_tvalid in the cycle after
// the byte is taken. No clearing pass follows reset.
module framed_command_matcher #(
    parameter int LINE_LEN = fcm_pkg::LINE_LEN_DEF,
    parameter int MAX_CMDS = fcm_pkg::MAX_CMDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] byte_value, [11:8] entry_index, [17:12] char_position, [21:18] handler_mask
    input  wire logic [23:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] matched_entry, [5:4] action, [6] handler_ran
    output logic [7:0]       m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int AW = $clog2(LINE_LEN);
    localparam int LW = $clog2(LINE_LEN + 1);
    localparam int CW = $clog2(MAX_CMDS + 1);
    localparam int IW = (MAX_CMDS > 1) ? $clog2(MAX_CMDS) : 1;
    localparam int NW = $clog2(MAX_CMDS * LINE_LEN);

    typedef enum logic [3:0] {
        S_IDLE, S_SC_RD, S_SC_EV, S_O0_RD, S_O0_EV, S_O1_RD, S_O1_EV,
        S_M_RD, S_M_EV, S_OUT
    } state_t;

    state_t        state_reg;
    logic [7:0]    eol_first_reg, eol_second_reg, sep_a_reg, sep_b_reg;
    logic          in_frame_reg;
    logic [LW-1:0] len_reg;
    logic [7:0]    prev_reg;
    logic [CW-1:0] count_reg;
    logic [3:0]    flags_reg [MAX_CMDS];
    logic [LW-1:0] ptr_reg, start_reg, tlen_reg, k_reg;
    logic          tok_reg;
    logic [7:0]    o0_reg, o1_reg;
    logic [CW-1:0] i_reg;
    logic [NW-1:0] base_reg;
    logic [1:0]    vst_reg, vact_reg;
    logic [3:0]    vent_reg;
    logic          vran_reg;
    logic          m_valid_reg;
    logic [1:0]    out_st_reg, out_act_reg;
    logic [3:0]    out_ent_reg;
    logic          out_ran_reg;

    logic [7:0]    lb_mem [LINE_LEN];
    logic [7:0]    lb_q_reg;
    logic [7:0]    nm_mem [MAX_CMDS * LINE_LEN];
    logic [7:0]    nm_q_reg;

    logic [7:0]    in_byte;
    logic [3:0]    in_entry;
    logic [5:0]    in_pos;
    logic [3:0]    in_mask;
    logic          accept, out_free, byte_store, ovf, eol_hit, name_wr;
    logic [LW-1:0] wr_idx, new_len;
    logic [7:0]    prev_chk;
    logic [NW-1:0] nm_waddr, nm_raddr;
    logic [7:0]    lb_data, tch;
    logic          lb_sep;
    logic [3:0]    fl;
    logic [1:0]    m_st, m_act;
    logic          m_ran;
    logic          cfg_wr;

    assign in_byte  = s_tdata[7:0];
    assign in_entry = s_tdata[11:8];
    assign in_pos   = s_tdata[17:12];
    assign in_mask  = s_tdata[21:18];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign byte_store = accept && s_tuser == fcm_pkg::KIND_BYTE && in_frame_reg
                        && in_byte != fcm_pkg::CH_CLOSE;
    assign ovf      = len_reg > LW'(LINE_LEN - 2);
    assign wr_idx   = ovf ? '0 : len_reg;
    assign new_len  = wr_idx + LW'(1);
    assign prev_chk = ovf ? 8'd0 : prev_reg;
    assign eol_hit  = new_len > LW'(2) && prev_chk == eol_first_reg
                      && in_byte == eol_second_reg;

    assign name_wr  = accept && s_tuser == fcm_pkg::KIND_NAME
                      && 32'(in_entry) < MAX_CMDS && 32'(in_pos) < LINE_LEN;
    assign nm_waddr = NW'(32'(in_entry) * LINE_LEN + 32'(in_pos));
    assign nm_raddr = base_reg + NW'(k_reg);

    // Positions at or past the line length read as zero: nothing stale is cleared.
    assign lb_data = (ptr_reg < len_reg) ? lb_q_reg : 8'd0;
    assign lb_sep  = lb_data == sep_a_reg || lb_data == sep_b_reg;
    assign tch     = (k_reg < tlen_reg) ? lb_q_reg : 8'd0;
    assign fl      = flags_reg[i_reg[IW-1:0]];

    always_comb begin
        m_ran = 1'b1;
        m_st  = fcm_pkg::ST_DISPATCHED;
        if (o0_reg == fcm_pkg::CH_EQ && o1_reg == fcm_pkg::CH_QM) begin
            m_act = fcm_pkg::ACT_TEST;
            m_ran = fl[0];
        end else if (o0_reg == fcm_pkg::CH_QM && fl[1]) begin
            m_act = fcm_pkg::ACT_READ;
        end else if (o0_reg == fcm_pkg::CH_EQ && fl[2]) begin
            m_act = fcm_pkg::ACT_WRITE;
        end else if (fl[3]) begin
            m_act = fcm_pkg::ACT_EXEC;
        end else begin
            m_act = fcm_pkg::ACT_EXEC;
            m_st  = fcm_pkg::ST_NO_HANDLER;
            m_ran = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_store) begin
            lb_mem[wr_idx[AW-1:0]] <= in_byte;
        end
        lb_q_reg <= lb_mem[ptr_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (name_wr) begin
            nm_mem[nm_waddr] <= in_byte;
        end
        nm_q_reg <= nm_mem[nm_raddr];
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            fcm_pkg::REG_EOL_FIRST:  prdata = {24'd0, eol_first_reg};
            fcm_pkg::REG_EOL_SECOND: prdata = {24'd0, eol_second_reg};
            fcm_pkg::REG_SEP_A:      prdata = {24'd0, sep_a_reg};
            fcm_pkg::REG_SEP_B:      prdata = {24'd0, sep_b_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eol_first_reg  <= fcm_pkg::EOL_FIRST_RST;
            eol_second_reg <= fcm_pkg::EOL_SECOND_RST;
            sep_a_reg      <= fcm_pkg::SEP_A_RST;
            sep_b_reg      <= fcm_pkg::SEP_B_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                fcm_pkg::REG_EOL_FIRST:  eol_first_reg  <= pwdata[7:0];
                fcm_pkg::REG_EOL_SECOND: eol_second_reg <= pwdata[7:0];
                fcm_pkg::REG_SEP_A:      sep_a_reg      <= pwdata[7:0];
                fcm_pkg::REG_SEP_B:      sep_b_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            in_frame_reg <= 1'b0;
            len_reg      <= '0;
            prev_reg     <= 8'd0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            for (int j = 0; j < MAX_CMDS; j++) begin
                flags_reg[j] <= 4'd0;
            end
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && s_tuser == fcm_pkg::KIND_FLAGS
                            && 32'(in_entry) < MAX_CMDS) begin
                        flags_reg[in_entry[IW-1:0]] <= in_mask;
                        if (32'(count_reg) < 32'(in_entry) + 1) begin
                            count_reg <= CW'(32'(in_entry) + 1);
                        end
                    end
                    if (accept && s_tuser == fcm_pkg::KIND_BYTE) begin
                        if (!in_frame_reg) begin
                            if (in_byte == fcm_pkg::CH_OPEN) in_frame_reg <= 1'b1;
                        end else if (in_byte == fcm_pkg::CH_CLOSE) begin
                            in_frame_reg <= 1'b0;
                        end
                    end
                    if (byte_store) begin
                        len_reg  <= new_len;
                        prev_reg <= in_byte;
                        if (ovf) begin
                            m_valid_reg <= 1'b1;
                            out_st_reg  <= fcm_pkg::ST_OVERFLOW;
                            out_act_reg <= fcm_pkg::ACT_TEST;
                            out_ent_reg <= 4'd0;
                            out_ran_reg <= 1'b0;
                        end
                        if (eol_hit) begin
                            ptr_reg   <= '0;
                            tok_reg   <= 1'b0;
                            start_reg <= '0;
                            state_reg <= S_SC_RD;
                        end
                    end
                end
                S_SC_RD: begin
                    if (ptr_reg == len_reg) begin
                        if (tok_reg) begin
                            tlen_reg  <= ptr_reg - start_reg;
                            ptr_reg   <= ptr_reg - start_reg;
                            state_reg <= S_O0_RD;
                        end else begin
                            vst_reg   <= fcm_pkg::ST_NO_MATCH;
                            vent_reg  <= 4'd0;
                            vact_reg  <= fcm_pkg::ACT_TEST;
                            vran_reg  <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        state_reg <= S_SC_EV;
                    end
                end
                S_SC_EV: begin
                    // End of string, or separator after the token: token is complete (with no token: no match).
                    if (lb_data == 8'd0 || (tok_reg && lb_sep)) begin
                        if (tok_reg) begin
                            tlen_reg  <= ptr_reg - start_reg;
                            ptr_reg   <= ptr_reg - start_reg;
                            state_reg <= S_O0_RD;
                        end else begin
                            vst_reg   <= fcm_pkg::ST_NO_MATCH;
                            vent_reg  <= 4'd0;
                            vact_reg  <= fcm_pkg::ACT_TEST;
                            vran_reg  <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        if (!tok_reg && !lb_sep) begin
                            tok_reg   <= 1'b1;
                            start_reg <= ptr_reg;
                        end
                        ptr_reg   <= ptr_reg + LW'(1);
                        state_reg <= S_SC_RD;
                    end
                end
                S_O0_RD: state_reg <= S_O0_EV;
                S_O0_EV: begin
                    o0_reg    <= lb_data;
                    ptr_reg   <= ptr_reg + LW'(1);
                    state_reg <= S_O1_RD;
                end
                S_O1_RD: state_reg <= S_O1_EV;
                S_O1_EV: begin
                    o1_reg    <= lb_data;
                    ptr_reg   <= start_reg;
                    k_reg     <= '0;
                    i_reg     <= '0;
                    base_reg  <= '0;
                    state_reg <= S_M_RD;
                end
                S_M_RD: begin
                    if (i_reg == count_reg) begin
                        vst_reg   <= fcm_pkg::ST_NO_MATCH;
                        vent_reg  <= 4'd0;
                        vact_reg  <= fcm_pkg::ACT_TEST;
                        vran_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_M_EV;
                    end
                end
                S_M_EV: begin
                    if (tch != nm_q_reg) begin
                        // Mismatch: move on to the next entry's name.
                        i_reg     <= i_reg + CW'(1);
                        base_reg  <= base_reg + NW'(LINE_LEN);
                        k_reg     <= '0;
                        ptr_reg   <= start_reg;
                        state_reg <= S_M_RD;
                    end else if (tch == 8'd0 || k_reg == LW'(LINE_LEN - 1)) begin
                        vst_reg   <= m_st;
                        vent_reg  <= 4'(i_reg);
                        vact_reg  <= m_act;
                        vran_reg  <= m_ran;
                        state_reg <= S_OUT;
                    end else begin
                        k_reg     <= k_reg + LW'(1);
                        ptr_reg   <= ptr_reg + LW'(1);
                        state_reg <= S_M_RD;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        out_st_reg  <= vst_reg;
                        out_act_reg <= vact_reg;
                        out_ent_reg <= vent_reg;
                        out_ran_reg <= vran_reg;
                        len_reg     <= '0;
                        prev_reg    <= 8'd0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = {1'b0, out_ran_reg, out_act_reg, out_ent_reg};
endmodule
`default_nettype wire

// ----- rtl/fcm_checker.sv -----
// Port-level checks for the framed command matcher, bound to the top level.
`default_nettype none
module fcm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer dropped while stalled");

    a_ovf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fcm_pkg::ST_OVERFLOW |-> m_tdata == 8'd0)
        else $error("overflow result carries entry or action");

    a_nomatch_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fcm_pkg::ST_NO_MATCH |-> m_tdata == 8'd0)
        else $error("no-match result carries entry or action");

    a_nohandler: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fcm_pkg::ST_NO_HANDLER
        |-> m_tdata[6:4] == {1'b0, fcm_pkg::ACT_EXEC})
        else $error("no-handler result must be execute without a run");
endmodule

bind framed_command_matcher fcm_checker u_fcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
